FILE: rtl/tle_pkg.sv
// shared types, byte codes and phrase table of the terminal line editor
`default_nettype none

package tle_pkg;

  // default line length in cells
  localparam int LINE_LEN_DEF = 32;

  // byte codes
  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_BEL = 8'd7;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_ESC = 8'd27;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_GT  = 8'd62;
  localparam logic [7:0] CH_A   = 8'd65;
  localparam logic [7:0] CH_B   = 8'd66;
  localparam logic [7:0] CH_C   = 8'd67;
  localparam logic [7:0] CH_D   = 8'd68;
  localparam logic [7:0] CH_F   = 8'd70;
  localparam logic [7:0] CH_LBR = 8'd91;
  localparam logic [7:0] CH_DEL = 8'd127;

  // result kinds
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  // fixed output phrases
  typedef enum logic [2:0] {
    PH_ONE   = 3'd0,  // single byte held in the char register
    PH_ERASE = 3'd1,  // BS SP BS
    PH_RIGHT = 3'd2,  // ESC [ C
    PH_HEAD  = 3'd3,  // CR LF ahead of the line
    PH_TAIL  = 3'd4   // CR LF and the prompt
  } phrase_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_PHRASE   = 4'b0010,
    S_LINE_RD  = 4'b0100,
    S_LINE_OUT = 4'b1000
  } state_t;

  // line store command
  typedef struct packed {
    logic wr;       // write cell, mark it nonzero
    logic clr;      // mark cell as zero
    logic clr_all;  // mark every cell as zero
    logic rd;       // registered read of cell
  } store_cmd_t;

  // index of the final byte of a phrase
  function automatic logic [2:0] phrase_end(phrase_t ph);
    logic [2:0] r;
    unique case (ph)
      PH_ONE:   r = 3'd0;
      PH_ERASE: r = 3'd2;
      PH_RIGHT: r = 3'd2;
      PH_HEAD:  r = 3'd1;
      PH_TAIL:  r = 3'd5;
      default:  r = 3'd0;
    endcase
    return r;
  endfunction

  // byte at a position of a phrase
  function automatic logic [7:0] phrase_byte(phrase_t ph, logic [2:0] idx, logic [7:0] chr);
    logic [7:0] r;
    r = chr;
    unique case (ph)
      PH_ONE:   r = chr;
      PH_ERASE: r = (idx == 3'd1) ? CH_SP : CH_BS;
      PH_RIGHT: begin
        unique case (idx)
          3'd0:    r = CH_ESC;
          3'd1:    r = CH_LBR;
          default: r = CH_C;
        endcase
      end
      PH_HEAD:  r = (idx == 3'd0) ? CH_CR : CH_LF;
      PH_TAIL: begin
        unique case (idx)
          3'd0:    r = CH_CR;
          3'd1:    r = CH_LF;
          3'd5:    r = CH_SP;
          default: r = CH_GT;
        endcase
      end
      default:  r = chr;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tle_store.sv
// line store memory with per-cell nonzero flags
`default_nettype none

module tle_store #(
  parameter int LINE_LEN = tle_pkg::LINE_LEN_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tle_pkg::store_cmd_t         cmd,
  input  wire logic [$clog2(LINE_LEN)-1:0] addr,
  input  wire logic [7:0]                  wdata,
  output logic [7:0]                       rd_data,
  output logic [LINE_LEN-1:0]              nz
);
  import tle_pkg::*;

  logic [7:0]          mem [LINE_LEN];
  logic [7:0]          rd_data_r;
  logic [LINE_LEN-1:0] nz_r;
  logic [LINE_LEN-1:0] nz_nxt;

  // cell memory, one write or one read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[addr];
    end
  end

  // nonzero flags, a cleared flag marks the cell as zero; the memory read ignores the flag
  always_comb begin
    nz_nxt = nz_r;
    if (cmd.clr_all) begin
      nz_nxt = '0;
    end else if (cmd.wr) begin
      nz_nxt[addr] = 1'b1;
    end else if (cmd.clr) begin
      nz_nxt[addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r <= '0;
    end else begin
      nz_r <= nz_nxt;
    end
  end

  assign rd_data = rd_data_r;
  assign nz      = nz_r;

endmodule

`default_nettype wire

FILE: rtl/tle_ctrl.sv
// byte decoder, cursor and escape state, and result sequencer
`default_nettype none

module tle_ctrl #(
  parameter int LINE_LEN = tle_pkg::LINE_LEN_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [7:0]                       out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast,
  output tle_pkg::store_cmd_t              st_cmd,
  output logic [$clog2(LINE_LEN)-1:0]      st_addr,
  output logic [7:0]                       st_wdata,
  input  wire logic [7:0]                  st_rd_data,
  input  wire logic [LINE_LEN-1:0]         st_nz
);
  import tle_pkg::*;

  localparam int CW = $clog2(LINE_LEN + 1);
  localparam int AW = $clog2(LINE_LEN);
  localparam logic [CW-1:0] LEN_C = CW'(LINE_LEN);

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cursor_r, cursor_nxt;
  logic           esc_r, esc_nxt;
  phrase_t        ph_r, ph_nxt;
  logic [2:0]     idx_r, idx_nxt;
  logic [7:0]     chr_r, chr_nxt;
  logic [CW-1:0]  line_i_r, line_i_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_data_r, out_data_nxt;
  logic           out_kind_r, out_kind_nxt;
  logic           out_last_r, out_last_nxt;

  logic [LINE_LEN:0] nz_ext;
  logic              out_free;
  logic              swallow;
  logic              printable;
  logic              can_right;
  logic              ph_done;

  assign nz_ext    = {1'b0, st_nz};
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign swallow   = (in_tdata == CH_BS) || (in_tdata == CH_TAB) || (in_tdata == CH_LF) ||
                     (in_tdata == CH_CR) || (in_tdata == CH_DEL) || (in_tdata == CH_ESC) ||
                     (in_tdata == CH_LBR);
  assign printable = (in_tdata >= CH_SP) && (in_tdata < CH_DEL);
  // right move needs a nonzero cell under the cursor
  assign can_right = (cursor_r != LEN_C) && nz_ext[cursor_r];
  assign ph_done   = (idx_r == phrase_end(ph_r));

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    esc_nxt       = esc_r;
    ph_nxt        = ph_r;
    idx_nxt       = idx_r;
    chr_nxt       = chr_r;
    line_i_nxt    = line_i_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    st_cmd        = '0;
    st_addr       = '0;
    st_wdata      = in_tdata;

    unique case (state_r)
      // decode an accepted byte, update the cursor and the store
      S_IDLE: begin
        if (in_tvalid && in_tdata != CH_NUL) begin
          idx_nxt = '0;
          if (esc_r) begin
            if (!swallow) begin
              esc_nxt = 1'b0;
              priority if (in_tdata == CH_A || in_tdata == CH_B) begin
                ph_nxt    = PH_ONE;
                chr_nxt   = CH_BEL;
                state_nxt = S_PHRASE;
              end else if ((in_tdata == CH_C || (in_tdata == CH_F && st_nz[0])) &&
                           can_right) begin
                cursor_nxt = cursor_r + 1'b1;
                ph_nxt     = PH_RIGHT;
                state_nxt  = S_PHRASE;
              end else if (in_tdata == CH_D && cursor_r != '0) begin
                cursor_nxt = cursor_r - 1'b1;
                ph_nxt     = PH_ONE;
                chr_nxt    = CH_BS;
                state_nxt  = S_PHRASE;
              end else begin
              end
            end
          end else if (printable) begin
            st_cmd.wr = 1'b1;
            if (cursor_r == LEN_C) begin
              // store full: wrap to the first cell silently
              st_addr    = '0;
              cursor_nxt = CW'(1);
            end else begin
              st_addr    = cursor_r[AW-1:0];
              cursor_nxt = cursor_r + 1'b1;
              ph_nxt     = PH_ONE;
              chr_nxt    = in_tdata;
              state_nxt  = S_PHRASE;
            end
          end else if (in_tdata == CH_BS || in_tdata == CH_DEL) begin
            state_nxt = S_PHRASE;
            if (cursor_r == '0) begin
              ph_nxt  = PH_ONE;
              chr_nxt = CH_BEL;
            end else begin
              cursor_nxt = cursor_r - 1'b1;
              st_cmd.clr = 1'b1;
              st_addr    = cursor_nxt[AW-1:0];
              ph_nxt     = PH_ERASE;
            end
          end else if (in_tdata == CH_TAB) begin
            ph_nxt    = PH_ONE;
            chr_nxt   = CH_BEL;
            state_nxt = S_PHRASE;
          end else if (in_tdata == CH_CR || in_tdata == CH_LF) begin
            cursor_nxt = '0;
            ph_nxt     = PH_HEAD;
            state_nxt  = S_PHRASE;
          end else if (in_tdata == CH_ESC) begin
            esc_nxt = 1'b1;
          end
        end
      end

      // emit a fixed phrase, one byte per free output slot
      S_PHRASE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = phrase_byte(ph_r, idx_r, chr_r);
          out_kind_nxt  = KIND_ECHO;
          out_last_nxt  = ph_done && (ph_r != PH_HEAD);
          if (ph_done) begin
            if (ph_r == PH_HEAD) begin
              line_i_nxt = '0;
              state_nxt  = S_LINE_RD;
            end else begin
              st_cmd.clr_all = (ph_r == PH_TAIL);
              state_nxt      = S_IDLE;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      // fetch the next line cell, stop at the first zero cell or at the end of the store
      S_LINE_RD: begin
        if (line_i_r == LEN_C || !nz_ext[line_i_r]) begin
          ph_nxt    = PH_TAIL;
          idx_nxt   = '0;
          state_nxt = S_PHRASE;
        end else begin
          st_cmd.rd = 1'b1;
          st_addr   = line_i_r[AW-1:0];
          state_nxt = S_LINE_OUT;
        end
      end

      // emit the fetched cell as a line byte
      S_LINE_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = st_rd_data;
          out_kind_nxt  = KIND_LINE;
          out_last_nxt  = 1'b0;
          line_i_nxt    = line_i_r + 1'b1;
          state_nxt     = S_LINE_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ph_r       <= ph_nxt;
    idx_r      <= idx_nxt;
    chr_r      <= chr_nxt;
    line_i_r   <= line_i_nxt;
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/terminal_line_editor_top.sv
// top level of the terminal line editor: sequencer and line store
// the first result of a byte is made in the phrase state after its transfer and
//   is registered in the output register once that register is free
// fixed phrases give one result per cycle while the output is not stalled; each line
//   byte takes a read state and an output state (registered read of the line memory)
// a byte that gives no result leaves the input open; the next byte is taken once the
//   last result of the previous one sits in the output register
// reset clears cursor, escape flag and the per-cell nonzero flags
`default_nettype none

module terminal_line_editor_top #(
  parameter int LINE_LEN = tle_pkg::LINE_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tuser,  // [0] kind
  output logic            out_tlast
);
  import tle_pkg::*;

  localparam int AW = $clog2(LINE_LEN);

  store_cmd_t          st_cmd;
  logic [AW-1:0]       st_addr;
  logic [7:0]          st_wdata;
  logic [7:0]          st_rd_data;
  logic [LINE_LEN-1:0] st_nz;

  // decoder and result sequencer
  tle_ctrl #(
    .LINE_LEN (LINE_LEN)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .st_cmd     (st_cmd),
    .st_addr    (st_addr),
    .st_wdata   (st_wdata),
    .st_rd_data (st_rd_data),
    .st_nz      (st_nz)
  );

  // line store
  tle_store #(
    .LINE_LEN (LINE_LEN)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (st_cmd),
    .addr    (st_addr),
    .wdata   (st_wdata),
    .rd_data (st_rd_data),
    .nz      (st_nz)
  );

endmodule

`default_nettype wire

FILE: rtl/tle_checker.sv
// port checker of the terminal line editor and its bind
`default_nettype none

module tle_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tuser,
  input wire logic       out_tlast
);
  import tle_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // a zero byte is ignored and the input stays open
  a_nul_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata == CH_NUL |=> in_tready)
    else $error("zero byte closed the input");

  // line bytes are printable and never end a burst
  a_line_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_LINE |->
      !out_tlast && out_tdata >= CH_SP && out_tdata < CH_DEL)
    else $error("bad line byte");

  // while the input is open only a final result may wait
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("input open with burst unfinished");

endmodule

bind terminal_line_editor_top tle_checker u_tle_checker (.*);

`default_nettype wire
